>>> rtl/drmsd_pkg.sv
// Constants, types and a shared arithmetic helper of the distance RMSD block.
`default_nettype none
package drmsd_pkg;

	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 20;
	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = PTR_W + 1;
	localparam int PT_W = 3 * COORD_BITS;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int ROOT_W = DIFF_W;
	localparam int SUM_W = 58;
	localparam int SUM_STEPS_W = $clog2(SUM_W + 1);
	localparam int DEN_W = 2 * CNT_W;
	localparam int OUT_W = 21;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] x;
		logic [SUM_W-1:0] r;
	} root_t;

	// One step of the digit-by-digit integer square root.
	function automatic root_t root_step(input logic [SUM_W-1:0] x, input logic [SUM_W-1:0] r,
		input logic [SUM_W-1:0] bitv);
		root_t o;
		logic [SUM_W:0] t;
		t = {1'b0, r} + {1'b0, bitv};
		if ({1'b0, x} >= t) begin
			o.x = x - t[SUM_W-1:0];
			o.r = (r >> 1) + bitv;
		end else begin
			o.x = x;
			o.r = r >> 1;
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> rtl/drmsd_pair_if.sv
// Input channel carrying one pair of matched points per transaction.
`default_nettype none
interface drmsd_pair_if;
	logic valid;
	logic ready;
	logic signed [drmsd_pkg::COORD_BITS-1:0] ax;
	logic signed [drmsd_pkg::COORD_BITS-1:0] ay;
	logic signed [drmsd_pkg::COORD_BITS-1:0] az;
	logic signed [drmsd_pkg::COORD_BITS-1:0] bx;
	logic signed [drmsd_pkg::COORD_BITS-1:0] by;
	logic signed [drmsd_pkg::COORD_BITS-1:0] bz;
	logic last_pair;

	modport source (output valid, ax, ay, az, bx, by, bz, last_pair, input ready);
	modport sink (input valid, ax, ay, az, bx, by, bz, last_pair, output ready);
endinterface
`default_nettype wire

>>> rtl/drmsd_result_if.sv
// Output channel carrying one distance RMSD result per transaction.
`default_nettype none
interface drmsd_result_if;
	logic valid;
	logic ready;
	logic [drmsd_pkg::OUT_W-1:0] drmsd;
	logic [drmsd_pkg::STATUS_W-1:0] status;

	modport source (output valid, drmsd, status, input ready);
	modport sink (input valid, drmsd, status, output ready);
endinterface
`default_nettype wire

>>> rtl/drmsd_of_paired_coordinates.sv
// Distance RMSD of paired point sets: each accepted pair is written to a 256-entry point
// memory and then compared with every pair stored before it, one stored pair read per cycle
// and fed into a pipeline of squared distances and 21 square-root stages. No new pair is
// accepted until the block is idle again, after the scan has drained through the pipeline;
// the scan goes through the point memory's single read port. The last pair adds a division
// of the deviation sum by the number of compared pairs and a square root before the result
// transaction is offered. A pair arriving with the memory full is dropped and the result
// reports overflow; a set of one pair reports too few.
`default_nettype none
module drmsd_of_paired_coordinates (
	input logic clk,
	input logic arst_n,
	drmsd_pair_if.sink pairs,
	drmsd_result_if.source results
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_DIV   = 6'b001000,
		S_ROOT  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	localparam int CW = drmsd_pkg::COORD_BITS;
	localparam int PW = drmsd_pkg::PT_W;
	localparam int DW = drmsd_pkg::DIFF_W;
	localparam int QW = drmsd_pkg::SQ_W;
	localparam int NS = drmsd_pkg::ROOT_STEPS;
	localparam int RW = drmsd_pkg::ROOT_W;
	localparam int SW = drmsd_pkg::SUM_W;
	localparam int NW = drmsd_pkg::DEN_W;
	localparam int OW = drmsd_pkg::OUT_W;
	localparam int CN = drmsd_pkg::CNT_W;
	localparam int PT = drmsd_pkg::PTR_W;

	function automatic logic [DW-1:0] abs_diff(input logic [CW-1:0] p, input logic [CW-1:0] q);
		logic signed [DW-1:0] d;
		d = signed'({p[CW-1], p}) - signed'({q[CW-1], q});
		return d[DW-1] ? DW'(-d) : DW'(d);
	endfunction

	state_t state_q;
	logic [CN-1:0] cnt_q;
	logic [CN-1:0] lim_q;
	logic [CN-1:0] scan_q;
	logic last_q;
	logic ovf_q;
	logic few_q;
	logic [SW-1:0] sum_q;
	logic [2*PW-1:0] cur_q;

	logic [2*PW-1:0] pts_mem [drmsd_pkg::MAX_POINTS];
	logic [2*PW-1:0] rd_s1;
	logic v_s1;
	logic [DW-1:0] dif_s2 [6];
	logic v_s2;
	logic [QW-1:0] rxa_s [NS+1];
	logic [QW-1:0] rra_s [NS+1];
	logic [QW-1:0] rxb_s [NS+1];
	logic [QW-1:0] rrb_s [NS+1];
	logic [NS:0] rv_s;
	drmsd_pkg::root_t sta [NS];
	drmsd_pkg::root_t stb [NS];
	logic [QW-1:0] sq_s;
	logic v_sq;

	logic [SW-1:0] div_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [drmsd_pkg::SUM_STEPS_W-1:0] step_q;
	logic [SW-1:0] rx_q;
	logic [SW-1:0] rr_q;
	logic [SW-1:0] bit_q;
	drmsd_pkg::root_t fin_step;

	logic [OW-1:0] out_drmsd_q;
	logic [drmsd_pkg::STATUS_W-1:0] out_status_q;
	logic out_v_q;

	logic acc;
	logic room;
	logic issue;
	logic busy;
	logic [NW:0] trial;
	logic [2*CN-1:0] npairs;
	logic [RW-1:0] root_a;
	logic [RW-1:0] root_b;
	logic [RW-1:0] root_d;
	logic [SW:0] sum_next;

	assign pairs.ready = (state_q == S_IDLE);
	assign acc = pairs.valid && pairs.ready;
	assign room = (cnt_q < CN'(drmsd_pkg::MAX_POINTS));
	assign issue = (state_q == S_SCAN) && (scan_q != lim_q);
	assign busy = v_s1 || v_s2 || (|rv_s) || v_sq;
	assign trial = {rem_q, div_q[SW-1]};
	assign npairs = (2*CN)'(cnt_q) * (2*CN)'(cnt_q - CN'(1));
	assign fin_step = drmsd_pkg::root_step(rx_q, rr_q, bit_q);

	assign results.valid = out_v_q;
	assign results.drmsd = out_drmsd_q;
	assign results.status = out_status_q;

	// Point memory: the new pair goes in at the fill count, reads only touch older entries.
	always_ff @(posedge clk) begin
		if (acc && room) begin
			pts_mem[cnt_q[PT-1:0]] <= {pairs.ax, pairs.ay, pairs.az,
				pairs.bx, pairs.by, pairs.bz};
		end
		rd_s1 <= pts_mem[scan_q[PT-1:0]];
	end

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			sta[i] = drmsd_pkg::root_step(SW'(rxa_s[i]), SW'(rra_s[i]),
				SW'(1) << (QW - 2 - 2 * i));
			stb[i] = drmsd_pkg::root_step(SW'(rxb_s[i]), SW'(rrb_s[i]),
				SW'(1) << (QW - 2 - 2 * i));
		end
	end

	assign root_a = rra_s[NS][RW-1:0];
	assign root_b = rrb_s[NS][RW-1:0];
	assign root_d = (root_a >= root_b) ? root_a - root_b : root_b - root_a;
	assign sum_next = {1'b0, sum_q} + (SW+1)'(sq_s);

	// Payload pipeline: coordinate differences, squared distances, roots, squared deviation.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			dif_s2[c] <= abs_diff(rd_s1[2*PW-1-c*CW -: CW], cur_q[2*PW-1-c*CW -: CW]);
			dif_s2[c+3] <= abs_diff(rd_s1[PW-1-c*CW -: CW], cur_q[PW-1-c*CW -: CW]);
		end
		rxa_s[0] <= QW'(dif_s2[0]) * QW'(dif_s2[0]) + QW'(dif_s2[1]) * QW'(dif_s2[1])
			+ QW'(dif_s2[2]) * QW'(dif_s2[2]);
		rxb_s[0] <= QW'(dif_s2[3]) * QW'(dif_s2[3]) + QW'(dif_s2[4]) * QW'(dif_s2[4])
			+ QW'(dif_s2[5]) * QW'(dif_s2[5]);
		rra_s[0] <= '0;
		rrb_s[0] <= '0;
		for (int i = 0; i < NS; i++) begin
			rxa_s[i+1] <= QW'(sta[i].x);
			rra_s[i+1] <= QW'(sta[i].r);
			rxb_s[i+1] <= QW'(stb[i].x);
			rrb_s[i+1] <= QW'(stb[i].r);
		end
		sq_s <= QW'(root_d) * QW'(root_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rv_s <= '0;
			v_sq <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			rv_s <= {rv_s[NS-1:0], v_s2};
			v_sq <= rv_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q <= {pairs.ax, pairs.ay, pairs.az, pairs.bx, pairs.by, pairs.bz};
		end
		if (state_q == S_DRAIN) begin
			div_q <= sum_q;
			rem_q <= '0;
			den_q <= NW'(npairs >> 1);
		end else if (state_q == S_DIV) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= NW'(trial - {1'b0, den_q});
				div_q <= {div_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= trial[NW-1:0];
				div_q <= {div_q[SW-2:0], 1'b0};
			end
		end
		if (state_q == S_DIV) begin
			rx_q <= {div_q[SW-2:0], trial >= {1'b0, den_q}};
			rr_q <= '0;
			bit_q <= SW'(1) << (SW - 2);
		end else if (state_q == S_ROOT) begin
			rx_q <= fin_step.x;
			rr_q <= fin_step.r;
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			lim_q <= '0;
			scan_q <= '0;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
			few_q <= 1'b0;
			sum_q <= '0;
			step_q <= '0;
			out_v_q <= 1'b0;
			out_drmsd_q <= '0;
			out_status_q <= drmsd_pkg::ST_OK;
		end else begin
			// In S_OUT the clear is skipped: the output register is loaded below once it is empty or being emptied.
			if (out_v_q && results.ready && (state_q != S_OUT)) begin
				out_v_q <= 1'b0;
			end
			if (v_sq) begin
				sum_q <= sum_next[SW] ? '1 : sum_next[SW-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						last_q <= pairs.last_pair;
						scan_q <= '0;
						if (room) begin
							lim_q <= cnt_q;
							cnt_q <= cnt_q + CN'(1);
							state_q <= S_SCAN;
						end else begin
							ovf_q <= 1'b1;
							lim_q <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CN'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!busy) begin
						step_q <= '0;
						few_q <= (cnt_q < CN'(2));
						if (!last_q) begin
							state_q <= S_IDLE;
						end else if (cnt_q < CN'(2)) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					step_q <= step_q + drmsd_pkg::SUM_STEPS_W'(1);
					if (step_q == drmsd_pkg::SUM_STEPS_W'(SW - 1)) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (bit_q[0]) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_v_q || results.ready) begin
						out_v_q <= 1'b1;
						if (few_q) begin
							out_drmsd_q <= '0;
							out_status_q <= drmsd_pkg::ST_TOO_FEW;
						end else begin
							out_drmsd_q <= (|rr_q[SW-1:OW]) ? '1 : rr_q[OW-1:0];
							out_status_q <= ovf_q ? drmsd_pkg::ST_OVERFLOW : drmsd_pkg::ST_OK;
						end
						cnt_q <= '0;
						sum_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> tb/drmsd_of_paired_coordinates_tb.sv
// Self-checking testbench of the distance RMSD block: directed sets, a full store and random sets.
`default_nettype none
module drmsd_of_paired_coordinates_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;
	localparam longint unsigned SUM_LIMIT = (64'd1 << drmsd_pkg::SUM_W) - 64'd1;
	localparam longint unsigned OUT_LIMIT = (64'd1 << drmsd_pkg::OUT_W) - 64'd1;

	typedef struct {
		logic [drmsd_pkg::OUT_W-1:0] drmsd;
		logic [drmsd_pkg::STATUS_W-1:0] status;
	} rmsd_result_t;

	logic clk;
	logic arst_n;
	drmsd_pair_if pairs ();
	drmsd_result_if results ();

	drmsd_of_paired_coordinates dut (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs),
		.results(results)
	);

	// Own copy of the stored sets and running sum.
	longint first_x[drmsd_pkg::MAX_POINTS], first_y[drmsd_pkg::MAX_POINTS];
	longint first_z[drmsd_pkg::MAX_POINTS];
	longint second_x[drmsd_pkg::MAX_POINTS], second_y[drmsd_pkg::MAX_POINTS];
	longint second_z[drmsd_pkg::MAX_POINTS];
	int stored_pairs;
	longint unsigned squared_deviation_sum;
	bit pair_dropped;

	rmsd_result_t expected_rmsd[$];
	int mismatches;
	int cycle_count;
	int gap_left;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned span(input longint dx, input longint dy, input longint dz);
		longint unsigned s;
		s = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
		return int_sqrt(s);
	endfunction

	// Updates the stored sets for one accepted pair and returns 1 when a result is due.
	function automatic bit predict_pair(input logic signed [drmsd_pkg::COORD_BITS-1:0] c[6],
		input bit last, output rmsd_result_t res);
		longint a[3], b[3];
		longint unsigned da, db, d, cnt, val;
		for (int i = 0; i < 3; i++) begin
			a[i] = c[i];
			b[i] = c[i+3];
		end
		if (stored_pairs < drmsd_pkg::MAX_POINTS) begin
			for (int k = 0; k < stored_pairs; k++) begin
				da = span(first_x[k] - a[0], first_y[k] - a[1], first_z[k] - a[2]);
				db = span(second_x[k] - b[0], second_y[k] - b[1], second_z[k] - b[2]);
				d = (da >= db) ? da - db : db - da;
				squared_deviation_sum += d * d;
				if (squared_deviation_sum > SUM_LIMIT)
					squared_deviation_sum = SUM_LIMIT;
			end
			first_x[stored_pairs] = a[0];
			first_y[stored_pairs] = a[1];
			first_z[stored_pairs] = a[2];
			second_x[stored_pairs] = b[0];
			second_y[stored_pairs] = b[1];
			second_z[stored_pairs] = b[2];
			stored_pairs++;
		end else begin
			pair_dropped = 1'b1;
		end
		if (!last)
			return 1'b0;
		if (stored_pairs < 2) begin
			res.drmsd = '0;
			res.status = drmsd_pkg::ST_TOO_FEW;
		end else begin
			cnt = longint'(stored_pairs) * longint'(stored_pairs - 1) / 2;
			val = int_sqrt(squared_deviation_sum / cnt);
			if (val > OUT_LIMIT)
				val = OUT_LIMIT;
			res.drmsd = val[drmsd_pkg::OUT_W-1:0];
			res.status = pair_dropped ? drmsd_pkg::ST_OVERFLOW : drmsd_pkg::ST_OK;
		end
		stored_pairs = 0;
		squared_deviation_sum = 0;
		pair_dropped = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_pair(input logic signed [drmsd_pkg::COORD_BITS-1:0] c[6],
		input bit last);
		rmsd_result_t res;
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
		end
		if (gap_left > 0) begin
			pairs.valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		burst_left--;
		pairs.valid <= 1'b1;
		pairs.ax <= c[0];
		pairs.ay <= c[1];
		pairs.az <= c[2];
		pairs.bx <= c[3];
		pairs.by <= c[4];
		pairs.bz <= c[5];
		pairs.last_pair <= last;
		do @(posedge clk); while (!pairs.ready);
		if (predict_pair(c, last, res))
			expected_rmsd.push_back(res);
	endtask

	function automatic logic signed [drmsd_pkg::COORD_BITS-1:0] rand_coord(input int mode);
		case (mode)
			0: return drmsd_pkg::COORD_BITS'($urandom);
			1: return drmsd_pkg::COORD_BITS'(int'($urandom_range(0, 4096)) - 2048);
			default: return ($urandom_range(0, 1) != 0) ?
				{1'b0, {(drmsd_pkg::COORD_BITS-1){1'b1}}} :
				{1'b1, {(drmsd_pkg::COORD_BITS-1){1'b0}}};
		endcase
	endfunction

	task automatic send_random_set(input int n, input int mode);
		logic signed [drmsd_pkg::COORD_BITS-1:0] c[6];
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < 6; j++)
				c[j] = rand_coord((mode == 3) ? $urandom_range(0, 2) : mode);
			send_pair(c, i == n - 1);
		end
	endtask

	task automatic test_single_pair();
		logic signed [drmsd_pkg::COORD_BITS-1:0] c[6];
		c = '{default: 0};
		send_pair(c, 1'b1);
		c = '{default: {1'b1, {(drmsd_pkg::COORD_BITS-1){1'b0}}}};
		send_pair(c, 1'b1);
	endtask

	task automatic test_extremes();
		logic signed [drmsd_pkg::COORD_BITS-1:0] lo, hi;
		logic signed [drmsd_pkg::COORD_BITS-1:0] c[6];
		lo = {1'b1, {(drmsd_pkg::COORD_BITS-1){1'b0}}};
		hi = {1'b0, {(drmsd_pkg::COORD_BITS-1){1'b1}}};
		// Opposite corners in the first set, one point repeated in the second.
		c = '{lo, lo, lo, hi, hi, hi};
		send_pair(c, 1'b0);
		c = '{hi, hi, hi, hi, hi, hi};
		send_pair(c, 1'b0);
		c = '{lo, hi, lo, lo, hi, hi};
		send_pair(c, 1'b1);
		c = '{hi, lo, hi, lo, hi, lo};
		send_pair(c, 1'b0);
		c = '{hi, lo, hi, lo, hi, lo};
		send_pair(c, 1'b1);
		send_random_set(5, 2);
	endtask

	task automatic test_full_store();
		// In each set the pairs beyond the store's capacity arrive with it full and are dropped.
		send_random_set(drmsd_pkg::MAX_POINTS + 1, 1);
		send_random_set(drmsd_pkg::MAX_POINTS + 3, 3);
	endtask

	task automatic test_random_sets();
		int sent;
		int n;
		sent = 0;
		while (sent < 560) begin
			n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
			send_random_set(n, ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(0, 1));
			sent += n;
		end
	endtask

	// Result side: ready follows a randomly drawn pattern, and each result is checked in order.
	always @(posedge clk) begin
		int pattern;
		rmsd_result_t exp_res;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("drmsd_of_paired_coordinates: mismatch");
			$finish;
		end
		if (cycle_count % 64 == 0)
			pattern = $urandom_range(0, 2);
		case (pattern)
			0: results.ready <= 1'b1;
			1: results.ready <= ($urandom_range(0, 2) != 0);
			default: results.ready <= (cycle_count % 7 < 3);
		endcase
		if (arst_n && results.valid && results.ready) begin
			if (expected_rmsd.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: drmsd %0d status %0d",
						results.drmsd, results.status);
			end else begin
				exp_res = expected_rmsd.pop_front();
				if (results.drmsd !== exp_res.drmsd || results.status !== exp_res.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result: expected drmsd %0d status %0d, got drmsd %0d status %0d",
							exp_res.drmsd, exp_res.status, results.drmsd, results.status);
				end
			end
		end
	end

	initial begin
		stored_pairs = 0;
		squared_deviation_sum = 0;
		pair_dropped = 1'b0;
		gap_left = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		pairs.valid <= 1'b0;
		pairs.ax <= '0;
		pairs.ay <= '0;
		pairs.az <= '0;
		pairs.bx <= '0;
		pairs.by <= '0;
		pairs.bz <= '0;
		pairs.last_pair <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_pair();
		test_extremes();
		test_full_store();
		test_random_sets();
		pairs.valid <= 1'b0;
		while (expected_rmsd.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("drmsd_of_paired_coordinates: match");
		else
			$display("drmsd_of_paired_coordinates: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
